[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check clocked on clk_i, off while rst_ni is low
`define MPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication check, antecedent and consequent given apart
`define MPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/mpq_pkg.sv]
// shared constants and types of the minimum priority queue
`default_nettype none

package mpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int PRI_W = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DELETED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [VAL_W-1:0] val;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic scan;
    logic shift;
    logic shift_init;
    logic reply;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic more;
    logic rd_pending;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[sv/mpq_datapath.sv]
// slot memory, scan and compaction pointers, minimum tracking and result register
`default_nettype none

module mpq_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mpq_pkg::cmd_t             cmd_i,
  output mpq_pkg::stat_t                 stat_o,
  input  wire logic                      in_kind_i,
  input  wire logic [mpq_pkg::VAL_W-1:0] in_value_i,
  input  wire logic [mpq_pkg::PRI_W-1:0] in_priority_i,
  output logic [mpq_pkg::VAL_W-1:0]      out_value_o,
  output logic [1:0]                     out_status_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i
);

  mpq_pkg::entry_t mem [mpq_pkg::DEPTH];

  logic                      kind_q;
  mpq_pkg::entry_t           item_q;
  logic [mpq_pkg::CNT_W-1:0] count_q;
  logic [mpq_pkg::CNT_W-1:0] ptr_q;
  logic                      rd_vld_q;
  logic [mpq_pkg::IDX_W-1:0] rd_idx_q;
  mpq_pkg::entry_t           rd_data_q;
  logic [mpq_pkg::IDX_W-1:0] best_idx_q;
  mpq_pkg::entry_t           best_q;
  logic                      out_vld_q;
  logic [mpq_pkg::VAL_W-1:0] out_value_q;
  logic [1:0]                out_status_q;

  logic                      full;
  logic                      empty;
  logic                      ins_ok;
  logic                      mem_we;
  logic [mpq_pkg::IDX_W-1:0] mem_wa;
  mpq_pkg::entry_t           mem_wd;

  assign full   = (count_q == mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
  assign empty  = (count_q == '0);
  assign ins_ok = cmd_i.reply && (kind_q == mpq_pkg::KIND_INSERT) && !full;

  assign stat_o.empty      = empty;
  assign stat_o.more       = (ptr_q < count_q);
  assign stat_o.rd_pending = rd_vld_q;
  assign stat_o.out_free   = !out_vld_q || out_ready_i;

  // compaction moves each read entry down one place; insert appends behind the live ones
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx_q - 1'b1;
    mem_wd = rd_data_q;
    if (cmd_i.shift && rd_vld_q) begin
      mem_we = 1'b1;
    end else if (ins_ok) begin
      mem_we = 1'b1;
      mem_wa = count_q[mpq_pkg::IDX_W-1:0];
      mem_wd = item_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[ptr_q[mpq_pkg::IDX_W-1:0]];
      rd_idx_q  <= ptr_q[mpq_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_kind_i;
      item_q.val <= in_value_i;
      item_q.pri <= in_priority_i;
    end
    // first entry seeds the minimum, strict compare keeps the earliest on ties
    if (cmd_i.scan && rd_vld_q &&
        ((rd_idx_q == '0) || (rd_data_q.pri < best_q.pri))) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.reply) begin
      if (kind_q == mpq_pkg::KIND_INSERT) begin
        out_value_q  <= '0;
        out_status_q <= full ? mpq_pkg::ST_FULL : mpq_pkg::ST_INSERTED;
      end else begin
        out_value_q  <= empty ? '0 : best_q.val;
        out_status_q <= empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_DELETED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        ptr_q <= '0;
      end else if (cmd_i.shift_init) begin
        ptr_q <= mpq_pkg::CNT_W'(best_idx_q) + 1'b1;
      end else if (cmd_i.issue) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.reply) begin
        out_vld_q <= 1'b1;
        if (ins_ok) begin
          count_q <= count_q + 1'b1;
        end else if ((kind_q == mpq_pkg::KIND_DELETE) && !empty) begin
          count_q <= count_q - 1'b1;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

[sv/mpq_ctrl.sv]
// sequencer for insert, minimum scan, compaction and reply
`default_nettype none

module mpq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_kind_i,
  output logic                in_ready_o,
  input  wire mpq_pkg::stat_t stat_i,
  output mpq_pkg::cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_REPLY = 5'b01000,
    S_SPARE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if ((in_kind_i == mpq_pkg::KIND_DELETE) && !stat_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_REPLY;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan  = 1'b1;
        cmd_o.issue = stat_i.more;
        if (!stat_i.more && !stat_i.rd_pending) begin
          cmd_o.issue      = 1'b0;
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.issue = stat_i.more;
        if (!stat_i.more && !stat_i.rd_pending) begin
          state_d = S_REPLY;
        end
      end
      S_REPLY: begin
        if (stat_i.out_free) begin
          cmd_o.reply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/min_priority_queue.sv]
// top level of the bounded minimum priority queue
//
//   channel  | dir | tdata                        | tuser
//   s_axis   | in  | item_value[31:0], item_priority[39:32] | kind
//   m_axis   | out | out_value[31:0]              | status[1:0]
//
// an insert, or a delete on an empty queue, has its result registered in the reply state
// once the output register is free, and the next item can be taken in the same cycle as
// the result turns valid; a delete over live entries has its result held back by the
// single read port of the slot memory, which the minimum scan and then the compaction
// walk one entry a cycle (the compaction only covers the entries behind the minimum).
// reset clears the live count; slot contents need no clearing.
// a result waits in the output register while the next item is already taken.
`default_nettype none

module min_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // item_value[31:0], item_priority[39:32]
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_value[31:0]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  mpq_pkg::cmd_t  cmd;
  mpq_pkg::stat_t stat;

  mpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mpq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_kind_i     (s_axis_tuser),
    .in_value_i    (s_axis_tdata[31:0]),
    .in_priority_i (s_axis_tdata[39:32]),
    .out_value_o   (m_axis_tdata),
    .out_status_o  (m_axis_tuser),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready)
  );

endmodule

`default_nettype wire

[sv/mpq_checker.sv]
// port-level checks of the priority queue, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module mpq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  `MPQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `MPQ_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `MPQ_ASSERT_IMP(a_zero_value, m_axis_tvalid && (m_axis_tuser != mpq_pkg::ST_DELETED), m_axis_tdata == '0, "value not zero outside a delete")
  `MPQ_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while one is at work")
  `MPQ_ASSERT_IMP(a_idle_on_result, $rose(m_axis_tvalid), s_axis_tready, "not ready for input after a result")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
